FILE: rtl/qdec_pkg.sv
`default_nettype none
package qdec_pkg;

   localparam int unsigned ENCODERS_DEFAULT     = 2;
   localparam int unsigned ELAPSED_BITS_DEFAULT = 10;

   localparam int unsigned LIMIT_BITS  = 10;
   localparam int unsigned SUM_BITS    = 4;
   localparam int unsigned STEP_BITS   = 5;
   localparam int unsigned PHASE_BITS  = 2;
   localparam int unsigned CSR_AW      = 4;
   localparam int unsigned CSR_DW      = 32;

   localparam logic [LIMIT_BITS-1:0] SLOW_LIMIT_RESET   = 10'd500;
   localparam logic [LIMIT_BITS-1:0] MEDIUM_LIMIT_RESET = 10'd200;
   localparam logic [LIMIT_BITS-1:0] FAST_LIMIT_RESET   = 10'd50;

   localparam logic signed [SUM_BITS-1:0] STEP_MICROSTEPS     = 4'sd4;
   localparam logic signed [SUM_BITS-1:0] STEP_MICROSTEPS_NEG = -4'sd4;

   typedef enum logic [1:0] {
      REG_SLOW_LIMIT   = 2'd0,
      REG_MEDIUM_LIMIT = 2'd1,
      REG_FAST_LIMIT   = 2'd2
   } reg_index_type;

   typedef enum logic {
      KIND_TICK   = 1'b0,
      KIND_SAMPLE = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0]      prev_phase;
      logic signed [SUM_BITS-1:0] sum;
   } enc_entry_type;

   function automatic logic signed [1:0] transition(input logic [3:0] idx);
      logic signed [1:0] d;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14:  d = 2'sb01;
         4'd2, 4'd4, 4'd11, 4'd13: d = 2'sb11;
         default:                  d = 2'sb00;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/quadrature_decoder_with_acceleration.sv
`default_nettype none
// A step event passes through the stage-1 registers and the output register before it leaves on rsp_tdata.
// Throughput: one beat per cycle unless stage 1 stalls; the state memory is read on accept and
// written back as stage 1 moves on, with the fresh write forwarded into a same-encoder read.
// Backpressure: a result held on rsp stalls req only when the next beat also yields one.
// Reset: synchronous; limits return to 500/200/50 ms, per-encoder valid bits and
// elapsed counters clear at once, so every encoder reads as zero state.
module quadrature_decoder_with_acceleration #(
   parameter int unsigned ENCODERS     = qdec_pkg::ENCODERS_DEFAULT,
   parameter int unsigned ELAPSED_BITS = qdec_pkg::ELAPSED_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [7:0]                    req_tdata,   // encoder[0], phase_ab[2:1]
   input  wire logic                          req_tuser,   // kind[0]
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [7:0]                    rsp_tdata,   // event_encoder[0], step_count[5:1]
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [qdec_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [qdec_pkg::CSR_DW-1:0]   csr_pwdata,
   output      logic [qdec_pkg::CSR_DW-1:0]   csr_prdata,
   output      logic                          csr_pready
);
   import qdec_pkg::*;

   localparam int unsigned ENC_AW = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;
   localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

   // configuration
   logic [LIMIT_BITS-1:0] slow_limit_ff, medium_limit_ff, fast_limit_ff;
   logic                  csr_we;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_limit_ff   <= SLOW_LIMIT_RESET;
         medium_limit_ff <= MEDIUM_LIMIT_RESET;
         fast_limit_ff   <= FAST_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_paddr[3:2])
            REG_SLOW_LIMIT:   slow_limit_ff   <= csr_pwdata[LIMIT_BITS-1:0];
            REG_MEDIUM_LIMIT: medium_limit_ff <= csr_pwdata[LIMIT_BITS-1:0];
            REG_FAST_LIMIT:   fast_limit_ff   <= csr_pwdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SLOW_LIMIT:   csr_prdata = CSR_DW'(slow_limit_ff);
         REG_MEDIUM_LIMIT: csr_prdata = CSR_DW'(medium_limit_ff);
         REG_FAST_LIMIT:   csr_prdata = CSR_DW'(fast_limit_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // input decode
   logic                  req_accept;
   logic                  req_enc;
   logic [PHASE_BITS-1:0] req_phase;
   logic                  req_in_range;
   logic [ENC_AW-1:0]     req_addr;

   assign req_accept   = req_tvalid & req_tready;
   assign req_enc      = req_tdata[0];
   assign req_phase    = req_tdata[2:1];
   assign req_in_range = (32'(req_enc) < ENCODERS);
   assign req_addr     = req_in_range ? ENC_AW'(req_enc) : '0;

   // state memory and per-entry valid bits
   enc_entry_type     mem [ENCODERS];
   logic              vld_ff [ENCODERS];
   logic              mem_we;
   logic [ENC_AW-1:0] mem_wa;
   enc_entry_type     mem_wd;

   // stage 1
   logic                  s1_valid_ff;
   logic                  s1_kind_ff;
   logic                  s1_in_range_ff;
   logic [ENC_AW-1:0]     s1_addr_ff;
   logic                  s1_enc_ff;
   logic [PHASE_BITS-1:0] s1_phase_ff;
   enc_entry_type         rd_ff;

   logic                        s1_go;
   logic                        s1_sample;
   logic                        s1_event;
   logic signed [1:0]           delta;
   logic signed [SUM_BITS-1:0]  sum_new;
   logic [ELAPSED_BITS-1:0]     s1_elapsed;
   logic signed [STEP_BITS-1:0] step_mag;
   logic signed [STEP_BITS-1:0] step_val;

   logic [ELAPSED_BITS-1:0] elapsed_ff [ENCODERS];
   logic [ELAPSED_BITS-1:0] elapsed_in [ENCODERS];

   logic                        rsp_valid_ff;
   logic                        rsp_enc_ff;
   logic signed [STEP_BITS-1:0] rsp_step_ff;

   assign s1_sample = s1_valid_ff & (s1_kind_ff == KIND_SAMPLE) & s1_in_range_ff;
   assign delta     = transition({rd_ff.prev_phase, s1_phase_ff});
   assign sum_new   = rd_ff.sum + {{(SUM_BITS-2){delta[1]}}, delta};
   assign s1_event  = s1_sample &
                      ((sum_new >= STEP_MICROSTEPS) || (sum_new <= STEP_MICROSTEPS_NEG));
   assign s1_go     = s1_valid_ff & (~s1_event | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_go;

   assign s1_elapsed = elapsed_ff[s1_addr_ff];

   always_comb begin
      if (s1_elapsed > ELAPSED_BITS'(slow_limit_ff)) begin
         step_mag = 5'sd1;
      end else if (s1_elapsed > ELAPSED_BITS'(medium_limit_ff)) begin
         step_mag = 5'sd2;
      end else if (s1_elapsed > ELAPSED_BITS'(fast_limit_ff)) begin
         step_mag = 5'sd4;
      end else begin
         step_mag = 5'sd8;
      end
      step_val = (sum_new > 4'sd0) ? step_mag : -step_mag;
   end

   assign mem_we        = s1_go & s1_sample;
   assign mem_wa        = s1_addr_ff;
   assign mem_wd.prev_phase = s1_phase_ff;
   assign mem_wd.sum    = s1_event ? '0 : sum_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENCODERS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (mem_we) begin
         vld_ff[mem_wa] <= 1'b1;
      end
   end

   // read on accept; forward a same-entry write of this edge
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (mem_we && (mem_wa == req_addr)) begin
            rd_ff <= mem_wd;
         end else if (vld_ff[req_addr]) begin
            rd_ff <= mem[req_addr];
         end else begin
            rd_ff <= '0;
         end
         s1_kind_ff     <= req_tuser;
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= req_addr;
         s1_enc_ff      <= req_enc;
         s1_phase_ff    <= req_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < ENCODERS; i++) begin
         elapsed_in[i] = elapsed_ff[i];
         if (s1_go && (s1_kind_ff == KIND_TICK)) begin
            if (elapsed_ff[i] != ELAPSED_MAX) begin
               elapsed_in[i] = elapsed_ff[i] + ELAPSED_BITS'(1);
            end
         end else if (s1_go && s1_event && (s1_addr_ff == ENC_AW'(i))) begin
            elapsed_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENCODERS; i++) begin
         if (reset) begin
            elapsed_ff[i] <= '0;
         end else begin
            elapsed_ff[i] <= elapsed_in[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_event) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_event) begin
         rsp_enc_ff  <= s1_enc_ff;
         rsp_step_ff <= step_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_step_ff, rsp_enc_ff};

   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_step_ff != '0))
      else $error("step event with zero step count");

   a_sum_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((mem_wd.sum < STEP_MICROSTEPS) && (mem_wd.sum > STEP_MICROSTEPS_NEG)))
      else $error("microstep sum written back out of range");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> !req_tready)
      else $error("input taken while stage 1 stalls");

   a_event_loads_output: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_event) |=> rsp_valid_ff)
      else $error("step event not loaded into output register");

   a_event_clears_elapsed: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_event) |=> (elapsed_ff[$past(s1_addr_ff)] == '0))
      else $error("elapsed counter not restarted after event");

endmodule
`default_nettype wire

FILE: tb/sv/quadrature_decoder_with_acceleration_test.sv
module quadrature_decoder_with_acceleration_test;
   import qdec_pkg::*;

   typedef struct packed {
      item_kind_type kind;
      logic          encoder;
      logic [1:0]    phase;
   } sample_beat_type;

   typedef struct packed {
      logic              encoder;
      logic signed [4:0] steps;
   } step_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // encoder[0], phase_ab[2:1]
   logic        req_tuser = 1'b0; // kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // event_encoder[0], step_count[5:1]
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   quadrature_decoder_with_acceleration dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   sample_beat_type pending_beats[$];
   step_event_type  step_events_due[$];
   int           errors = 0;
   int           phase_items = 0;

   // decoder state as the block should hold it
   int         microstep_delta[16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};
   logic [1:0] phase_seen[2] = '{2'd0, 2'd0};
   int         microstep_acc[2] = '{0, 0};
   logic [9:0] ms_since_step[2] = '{10'd0, 10'd0};
   logic [9:0] slow_ms = SLOW_LIMIT_RESET;
   logic [9:0] medium_ms = MEDIUM_LIMIT_RESET;
   logic [9:0] fast_ms = FAST_LIMIT_RESET;

   // phase each encoder is left at by the stimulus queued so far
   logic [1:0] walk_phase[2] = '{2'd0, 2'd0};

   int gap_left = 0;
   int burst_left = 1;

   bit long_hold_armed = 1'b0;
   int long_hold_count = 0;
   int pattern_left = 0;
   int pattern_mode = 0;
   bit toggle = 1'b0;

   function automatic void advance_decoder(input sample_beat_type b);
      logic [3:0]  idx;
      int          mult;
      step_event_type ev;
      if (b.kind == KIND_TICK) begin
         foreach (ms_since_step[i]) if (ms_since_step[i] != 10'h3FF) ms_since_step[i]++;
         return;
      end
      idx = {phase_seen[b.encoder], b.phase};
      phase_seen[b.encoder] = b.phase;
      microstep_acc[b.encoder] += microstep_delta[idx];
      if (microstep_acc[b.encoder] >= 4 || microstep_acc[b.encoder] <= -4) begin
         if (ms_since_step[b.encoder] > slow_ms) mult = 1;
         else if (ms_since_step[b.encoder] > medium_ms) mult = 2;
         else if (ms_since_step[b.encoder] > fast_ms) mult = 4;
         else mult = 8;
         ev.encoder = b.encoder;
         ev.steps = 5'((microstep_acc[b.encoder] > 0) ? mult : -mult);
         microstep_acc[b.encoder] = microstep_acc[b.encoder] % 4;
         ms_since_step[b.encoder] = '0;
         step_events_due.push_back(ev);
      end
   endfunction

   function automatic logic [1:0] gray_next(input logic [1:0] p, input bit up);
      case (p)
         2'd0: return up ? 2'd1 : 2'd2;
         2'd1: return up ? 2'd3 : 2'd0;
         2'd3: return up ? 2'd2 : 2'd1;
         default: return up ? 2'd0 : 2'd3;
      endcase
   endfunction

   task automatic push_sample(input logic enc, input logic [1:0] ph);
      pending_beats.push_back('{KIND_SAMPLE, enc, ph});
      walk_phase[enc] = ph;
      phase_items++;
   endtask

   task automatic push_ticks(input int n);
      repeat (n) begin
         pending_beats.push_back('{KIND_TICK, 1'(($urandom_range(0, 1))), 2'($urandom_range(0, 3))});
         phase_items++;
      end
   endtask

   task automatic walk(input logic enc, input bit up, input int n);
      repeat (n) push_sample(enc, gray_next(walk_phase[enc], up));
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_tvalid || step_events_due.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_limit(input reg_index_type r, input logic [9:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({r, 2'b00});
      csr_pwdata <= {22'($urandom), v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (r)
         REG_SLOW_LIMIT:   slow_ms = v;
         REG_MEDIUM_LIMIT: medium_ms = v;
         default:          fast_ms = v;
      endcase
   endtask

   task automatic set_limits(input logic [9:0] s, input logic [9:0] m, input logic [9:0] f);
      write_limit(REG_SLOW_LIMIT, s);
      write_limit(REG_MEDIUM_LIMIT, m);
      write_limit(REG_FAST_LIMIT, f);
      @(negedge clock);
   endtask

   task automatic random_phase(input int n);
      int r;
      phase_items = 0;
      while (phase_items < n) begin
         r = $urandom_range(0, 99);
         if (r < 55)
            walk(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom_range(1, 8));
         else if (r < 85)
            push_ticks(($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 6));
         else
            push_sample(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      end
   endtask

   always @(posedge clock) begin : sender
      logic next_valid;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_decoder('{item_kind_type'(req_tuser), req_tdata[0], req_tdata[2:1]});
            void'(pending_beats.pop_front());
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() > 0) begin
               next_valid = 1'b1;
               req_tuser <= pending_beats[0].kind;
               req_tdata <= {5'b0, pending_beats[0].phase, pending_beats[0].encoder};
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_tvalid <= next_valid;
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_armed && long_hold_count < 400) begin
         long_hold_count++;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 80);
            pattern_mode = $urandom_range(0, 3);
         end
         pattern_left--;
         toggle = ~toggle;
         case (pattern_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= toggle;
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      step_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (step_events_due.size() == 0) begin
            $display("%0t: unexpected step event: actual encoder %0d steps %0d", $time,
                     rsp_tdata[0], $signed(rsp_tdata[5:1]));
            errors++;
         end else begin
            want = step_events_due.pop_front();
            if (rsp_tdata[0] !== want.encoder) begin
               $display("%0t: event_encoder mismatch: expected %0d actual %0d", $time,
                        want.encoder, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[5:1] !== want.steps) begin
               $display("%0t: step_count mismatch: expected %0d actual %0d", $time,
                        want.steps, $signed(rsp_tdata[5:1]));
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [9:0] f, m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      walk(1'b0, 1'b1, 4);
      walk(1'b1, 1'b0, 4);
      push_sample(1'b0, 2'd0);
      push_sample(1'b0, 2'd3);
      push_sample(1'b0, 2'd0);
      push_sample(1'b1, 2'd3);
      push_sample(1'b1, 2'd0);
      walk(1'b1, 1'b1, 2);
      walk(1'b1, 1'b0, 2);
      push_ticks(2);
      drain();

      // saturate the elapsed counters
      push_ticks(1030);
      walk(1'b1, 1'b0, 4);
      walk(1'b0, 1'b1, 4);
      random_phase(50);
      drain();

      set_limits(10'd0, 10'd0, 10'd0);
      random_phase(60);
      drain();

      set_limits(10'd1023, 10'd1023, 10'd1023);
      long_hold_armed = 1'b1;
      random_phase(120);
      drain();

      set_limits(10'd50, 10'd200, 10'd500);
      random_phase(60);
      drain();

      repeat (6) begin
         f = 10'($urandom_range(0, 15));
         m = f + 10'($urandom_range(0, 20));
         set_limits(m + 10'($urandom_range(0, 30)), m, f);
         random_phase(25);
         drain();
      end

      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("quadrature_decoder_with_acceleration_test: PASS");
      end else begin
         $display("quadrature_decoder_with_acceleration_test: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("quadrature_decoder_with_acceleration_test: FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/qdec_pkg.sv
rtl/quadrature_decoder_with_acceleration.sv
tb/sv/quadrature_decoder_with_acceleration_test.sv
